// File: hw/rtl/aaline_pkg.sv
// Shared types and constants for the antialiased line generator.
`timescale 1ns / 1ps

package aaline_pkg;

  // Coordinate width of the payload and default fraction width of the slope
  localparam int COORD_BITS     = 9;
  localparam int FRAC_BITS_DFLT = 16;

  // Color and configuration widths
  localparam int COLOR_BITS = 8;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  // Command codes carried in the mode field
  localparam logic MODE_LINE = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd2;

  // Configuration reset values
  localparam logic [CFG_DATA_W-1:0] SCREEN_WIDTH_RST  = 9'd400;
  localparam logic [CFG_DATA_W-1:0] SCREEN_HEIGHT_RST = 9'd240;

  // One input item
  typedef struct packed {
    logic                  mode;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
    logic [COLOR_BITS-1:0] alpha;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] out_red;
    logic [COLOR_BITS-1:0] out_green;
    logic [COLOR_BITS-1:0] out_blue;
    logic [COLOR_BITS-1:0] coverage_alpha;
    logic                  last_of_step;
    logic                  line_done;
  } out_item_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hw/rtl/aaline_div.sv
// Radix-2 restoring divider that computes the line slope magnitude.
`timescale 1ns / 1ps

module aaline_div
  import aaline_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DFLT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [COORD_BITS-1:0] dividend,
  input  logic [COORD_BITS-1:0] divisor,
  output div_stat_t             stat,
  output logic [FRAC_BITS:0]    quot
);

  localparam int CB = COORD_BITS;
  localparam int NW = COORD_BITS + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CB-1:0] rem_r, rem_nxt;
  logic [CB-1:0] den_r, den_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [CB:0]   trial;
  logic [CB:0]   diff;
  logic          ge;

  // One quotient bit per cycle: shift in the next dividend bit and try a subtract
  assign trial = {rem_r, num_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
      rem_nxt  = '0;
      den_nxt  = divisor;
      num_nxt  = {dividend, {FRAC_BITS{1'b0}}};
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[CB-1:0] : trial[CB-1:0];
      num_nxt = {num_r[NW-2:0], 1'b0};
      quo_nxt = {quo_r[NW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
  end

  // The slope magnitude never exceeds one, so the low bits hold it
  assign quot      = quo_r[FRAC_BITS:0];
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: hw/rtl/antialiased_line_generator.sv
// Top level of the antialiased line generator: sequencer, step datapath, output register.
`timescale 1ns / 1ps
//
// Draws Wu-style antialiased lines, one major column per step item.
// Input channel (in_valid/in_stall/in_data): mode 0 loads a line command
// (endpoints and RGBA color) and returns nothing; mode 1 steps one column and
// returns up to two pixels on the result channel (out_valid/out_stall/out_data).
// A step while no line is active is dropped. Zero-coverage pixels, and with
// clipping on, out-of-screen pixels, are not sent.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready; the user
// must write it only while the block is idle, as the block does not enforce this.
// Stalls: a line command holds in_stall while the one-bit-per-cycle slope divider
// runs; a single-point command does not stall. A step holds in_stall while its
// pixels go out, one pixel per cycle through the single output register when the
// receiver does not stall that register, and for longer while it does.
// The first pixel sent passes through state S_PIX0 and the output register, with
// S_PIX1 between them when only the second pixel of the column is sent.
// Reset (rst_n low, synchronous) ends any line, empties the output register
// and restores clip off, 400 x 240 screen.
//
module antialiased_line_generator
  import aaline_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DFLT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CB = COORD_BITS;
  localparam int UW = COORD_BITS + 1;
  localparam int AW = COORD_BITS + FRAC_BITS;
  localparam int SW = FRAC_BITS + 2;
  localparam int QW = FRAC_BITS + 1;
  localparam int PW = FRAC_BITS + COLOR_BITS;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_PIX0 = 4'b0100,
    S_PIX1 = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    busy_r, busy_nxt;
  logic                    steep_r, steep_nxt;
  logic                    neg_r, neg_nxt;
  logic [CB-1:0]           col_r, col_nxt;
  logic [CB-1:0]           stop_r, stop_nxt;
  logic [AW-1:0]           acc_r, acc_nxt;
  logic signed [SW-1:0]    slope_r, slope_nxt;
  logic [COLOR_BITS-1:0]   red_r, red_nxt;
  logic [COLOR_BITS-1:0]   green_r, green_nxt;
  logic [COLOR_BITS-1:0]   blue_r, blue_nxt;
  logic [COLOR_BITS-1:0]   alpha_r, alpha_nxt;
  logic [CB-1:0]           p_ip_r, p_ip_nxt;
  logic [CB-1:0]           p_col_r, p_col_nxt;
  logic [COLOR_BITS-1:0]   p_a0_r, p_a0_nxt;
  logic [COLOR_BITS-1:0]   p_a1_r, p_a1_nxt;
  logic                    p_done_r, p_done_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;
  logic                    clip_r;
  logic [CFG_DATA_W-1:0]   scr_w_r;
  logic [CFG_DATA_W-1:0]   scr_h_r;

  // Line setup
  logic [CB-1:0]           adx, ady;
  logic                    steep;
  logic [CB-1:0]           s_ax, s_ay, s_bx, s_by;
  logic [CB-1:0]           o_ax, o_ay, o_bx, o_by;
  logic [CB-1:0]           dx, dy_mag;
  logic                    dy_neg;

  // Step datapath
  logic [PW-1:0]           prod;
  logic [COLOR_BITS-1:0]   a1_val, a0_val;
  logic [CB-1:0]           col_inc;
  logic [UW-1:0]           ip0_u, ip1_u, col_u;
  logic [UW-1:0]           x0_u, y0_u, x1_u, y1_u;
  logic [UW-1:0]           w_u, h_u;
  logic                    e0, e1;
  logic                    out_free;

  div_stat_t               div_stat;
  logic                    div_start;
  logic [QW-1:0]           quot;
  logic [SW-1:0]           q_ext;

  aaline_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(dy_mag),
    .divisor (dx),
    .stat    (div_stat),
    .quot    (quot)
  );

  // Classify the line, swap axes when steep and order by major coordinate
  always_comb begin
    adx   = (in_data.end_x >= in_data.start_x) ? in_data.end_x - in_data.start_x
                                               : in_data.start_x - in_data.end_x;
    ady   = (in_data.end_y >= in_data.start_y) ? in_data.end_y - in_data.start_y
                                               : in_data.start_y - in_data.end_y;
    steep = ady > adx;
    s_ax  = steep ? in_data.start_y : in_data.start_x;
    s_ay  = steep ? in_data.start_x : in_data.start_y;
    s_bx  = steep ? in_data.end_y : in_data.end_x;
    s_by  = steep ? in_data.end_x : in_data.end_y;
    if (s_ax > s_bx) begin
      o_ax = s_bx;
      o_ay = s_by;
      o_bx = s_ax;
      o_by = s_ay;
    end else begin
      o_ax = s_ax;
      o_ay = s_ay;
      o_bx = s_bx;
      o_by = s_by;
    end
    dx     = o_bx - o_ax;
    dy_neg = o_by < o_ay;
    dy_mag = dy_neg ? o_ay - o_by : o_by - o_ay;
  end

  // Coverage split: a1 = frac*a truncated, a0 = a - ceil(frac*a)
  assign prod    = PW'(acc_r[FRAC_BITS-1:0]) * PW'(alpha_r);
  assign a1_val  = prod[PW-1:FRAC_BITS];
  assign a0_val  = alpha_r - a1_val - COLOR_BITS'(|prod[FRAC_BITS-1:0]);
  assign col_inc = col_r + CB'(1);
  assign q_ext   = SW'(quot);

  // Unwrapped pixel positions and emit decisions for the pending step
  assign ip0_u = {1'b0, p_ip_r};
  assign ip1_u = ip0_u + UW'(1);
  assign col_u = {1'b0, p_col_r};
  assign x0_u  = steep_r ? ip0_u : col_u;
  assign y0_u  = steep_r ? col_u : ip0_u;
  assign x1_u  = steep_r ? ip1_u : col_u;
  assign y1_u  = steep_r ? col_u : ip1_u;
  assign w_u   = UW'(scr_w_r);
  assign h_u   = UW'(scr_h_r);
  assign e0    = (p_a0_r != '0) && !(clip_r && ((x0_u >= w_u) || (y0_u >= h_u)));
  assign e1    = (p_a1_r != '0) && !(clip_r && ((x1_u >= w_u) || (y1_u >= h_u)));

  assign out_free = !out_valid_r || !out_stall;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    steep_nxt     = steep_r;
    neg_nxt       = neg_r;
    col_nxt       = col_r;
    stop_nxt      = stop_r;
    acc_nxt       = acc_r;
    slope_nxt     = slope_r;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    alpha_nxt     = alpha_r;
    p_ip_nxt      = p_ip_r;
    p_col_nxt     = p_col_r;
    p_a0_nxt      = p_a0_r;
    p_a1_nxt      = p_a1_r;
    p_done_nxt    = p_done_r;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.mode == MODE_LINE) begin
            // Latch the command; the slope comes from the divider, or is zero for a single point
            steep_nxt = steep;
            neg_nxt   = dy_neg;
            col_nxt   = o_ax;
            stop_nxt  = o_bx;
            acc_nxt   = {o_ay, {FRAC_BITS{1'b0}}};
            red_nxt   = in_data.red;
            green_nxt = in_data.green;
            blue_nxt  = in_data.blue;
            alpha_nxt = in_data.alpha;
            busy_nxt  = 1'b0;
            if (dx == '0) begin
              slope_nxt = '0;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end else if (busy_r) begin
            // Capture this column's pixels, then advance the line
            p_ip_nxt   = acc_r[AW-1:FRAC_BITS];
            p_col_nxt  = col_r;
            p_a0_nxt   = a0_val;
            p_a1_nxt   = a1_val;
            p_done_nxt = col_inc == stop_r;
            acc_nxt    = acc_r + AW'(slope_r);
            col_nxt    = col_inc;
            busy_nxt   = col_inc != stop_r;
            state_nxt  = S_PIX0;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          slope_nxt = neg_r ? SW'(0) - q_ext : q_ext;
          busy_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_PIX0: begin
        if (!e0) begin
          state_nxt = e1 ? S_PIX1 : S_IDLE;
        end else if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.pixel_x        = x0_u[CB-1:0];
          out_data_nxt.pixel_y        = y0_u[CB-1:0];
          out_data_nxt.out_red        = red_r;
          out_data_nxt.out_green      = green_r;
          out_data_nxt.out_blue       = blue_r;
          out_data_nxt.coverage_alpha = p_a0_r;
          out_data_nxt.last_of_step   = !e1;
          out_data_nxt.line_done      = p_done_r;
          state_nxt                   = e1 ? S_PIX1 : S_IDLE;
        end
      end
      S_PIX1: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.pixel_x        = x1_u[CB-1:0];
          out_data_nxt.pixel_y        = y1_u[CB-1:0];
          out_data_nxt.out_red        = red_r;
          out_data_nxt.out_green      = green_r;
          out_data_nxt.out_blue       = blue_r;
          out_data_nxt.coverage_alpha = p_a1_r;
          out_data_nxt.last_of_step   = 1'b1;
          out_data_nxt.line_done      = p_done_r;
          state_nxt                   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Line and pending-step datapath
  always_ff @(posedge clk) begin
    steep_r    <= steep_nxt;
    neg_r      <= neg_nxt;
    col_r      <= col_nxt;
    stop_r     <= stop_nxt;
    acc_r      <= acc_nxt;
    slope_r    <= slope_nxt;
    red_r      <= red_nxt;
    green_r    <= green_nxt;
    blue_r     <= blue_nxt;
    alpha_r    <= alpha_nxt;
    p_ip_r     <= p_ip_nxt;
    p_col_r    <= p_col_nxt;
    p_a0_r     <= p_a0_nxt;
    p_a1_r     <= p_a1_nxt;
    p_done_r   <= p_done_nxt;
    out_data_r <= out_data_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r  <= 1'b0;
      scr_w_r <= SCREEN_WIDTH_RST;
      scr_h_r <= SCREEN_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CLIP_ENABLE:   clip_r  <= cfg_data[0];
        CFG_SCREEN_WIDTH:  scr_w_r <= cfg_data;
        CFG_SCREEN_HEIGHT: scr_h_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The divider only runs while the sequencer waits on it
  a_div_in_div_state : assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> state_r == S_DIV)
    else $error("divider busy outside the divide state");

  // A line becomes active only when the slope division finishes
  a_busy_from_div : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(state_r) == S_DIV && $past(div_stat.done))
    else $error("line activated without a finished slope");

  // Zero-coverage pixels are never sent
  a_no_zero_alpha : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.coverage_alpha != '0)
    else $error("pixel with zero coverage sent");

endmodule

// File: bench/aaline_pixel_checker.sv
// Pixel checker for the antialiased line generator: tracks line state, predicts and compares pixels.
`timescale 1ns / 1ps

module aaline_pixel_checker
  import aaline_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    pending_count
);

  localparam int     FRAC      = FRAC_BITS_DFLT;
  localparam longint FRAC_UNIT = longint'(1) << FRAC;

  // Clip registers as last written
  logic                  clip_on;
  logic [CFG_DATA_W-1:0] clip_w;
  logic [CFG_DATA_W-1:0] clip_h;

  // Line in progress
  logic                  drawing;
  logic                  steep;
  logic [COORD_BITS-1:0] column;
  logic [COORD_BITS-1:0] last_column;
  longint                intercept;
  longint                slope;
  logic [COLOR_BITS-1:0] col_r, col_g, col_b, col_a;

  // Pixels predicted but not yet seen on the result channel
  out_item_t pixel_q [$];
  int        errors = 0;

  assign mismatch_count = errors;

  function automatic string pixel_text(input out_item_t p);
    return $sformatf("x=%0d y=%0d rgb=%02h%02h%02h cov=%0d last=%0b done=%0b",
                     p.pixel_x, p.pixel_y, p.out_red, p.out_green, p.out_blue,
                     p.coverage_alpha, p.last_of_step, p.line_done);
  endfunction

  // Latch a line command: orient axes, order endpoints, divide for the slope
  task automatic load_line(input in_item_t cmd);
    int     ax, ay, bx, by, t, adx, ady, dx, dy;
    longint mag;
    ax  = int'(cmd.start_x);
    ay  = int'(cmd.start_y);
    bx  = int'(cmd.end_x);
    by  = int'(cmd.end_y);
    adx = (bx >= ax) ? bx - ax : ax - bx;
    ady = (by >= ay) ? by - ay : ay - by;
    steep = (ady > adx);
    if (ady > adx) begin
      t = ax; ax = ay; ay = t;
      t = bx; bx = by; by = t;
    end
    if (ax > bx) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    dx = bx - ax;
    dy = by - ay;
    col_r       = cmd.red;
    col_g       = cmd.green;
    col_b       = cmd.blue;
    col_a       = cmd.alpha;
    column      = COORD_BITS'(ax);
    last_column = COORD_BITS'(bx);
    intercept   = longint'(ay) * FRAC_UNIT;
    if (dx == 0) begin
      slope   = 0;
      drawing = 1'b0;
    end else begin
      mag     = (longint'(dy < 0 ? -dy : dy) * FRAC_UNIT) / dx;
      slope   = (dy < 0) ? -mag : mag;
      drawing = 1'b1;
    end
  endtask

  // One column: up to two pixels split by the intercept fraction
  task automatic trace_column();
    out_item_t cand [2];
    int        n, k;
    longint    ipart, fpart, a0, a1, minor, cov, px, py;
    bit        done;
    n     = 0;
    ipart = 0;
    fpart = 0;
    if (!drawing) return;
    if (intercept > 0) begin
      ipart = intercept >>> FRAC;
      fpart = intercept & (FRAC_UNIT - 1);
    end
    a0 = ((FRAC_UNIT - fpart) * longint'(col_a)) >>> FRAC;
    a1 = (fpart * longint'(col_a)) >>> FRAC;
    for (k = 0; k < 2; k++) begin
      minor = ipart + k;
      cov   = (k == 0) ? a0 : a1;
      px    = steep ? minor : longint'(column);
      py    = steep ? longint'(column) : minor;
      // drop zero coverage and, with clipping, anything off screen
      if (cov != 0 && !(clip_on && (px >= longint'(clip_w) || py >= longint'(clip_h)))) begin
        cand[n].pixel_x        = COORD_BITS'(px);
        cand[n].pixel_y        = COORD_BITS'(py);
        cand[n].out_red        = col_r;
        cand[n].out_green      = col_g;
        cand[n].out_blue       = col_b;
        cand[n].coverage_alpha = COLOR_BITS'(cov);
        cand[n].last_of_step   = 1'b0;
        cand[n].line_done      = 1'b0;
        n++;
      end
    end
    intercept = intercept + slope;
    column    = column + 1'b1;
    done      = (column == last_column);
    if (done) drawing = 1'b0;
    for (k = 0; k < n; k++) begin
      cand[k].line_done    = done;
      cand[k].last_of_step = (k == n - 1);
      pixel_q.push_back(cand[k]);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_CLIP_ENABLE:   clip_on = val[0];
      CFG_SCREEN_WIDTH:  clip_w  = val;
      CFG_SCREEN_HEIGHT: clip_h  = val;
      default: ;
    endcase
  endtask

  // Compare a pixel against the oldest prediction
  task automatic check_pixel(input out_item_t got);
    out_item_t want;
    bit        bad;
    if (pixel_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected pixel: got %s", pixel_text(got));
    end else begin
      want = pixel_q.pop_front();
      bad  = (got.pixel_x !== want.pixel_x) || (got.pixel_y !== want.pixel_y) ||
             (got.out_red !== want.out_red) || (got.out_green !== want.out_green) ||
             (got.out_blue !== want.out_blue) ||
             (got.coverage_alpha !== want.coverage_alpha) ||
             (got.last_of_step !== want.last_of_step) || (got.line_done !== want.line_done);
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display("pixel mismatch: expected %s, got %s", pixel_text(want), pixel_text(got));
      end
    end
  endtask

  // Sample every channel at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clip_on     = 1'b0;
      clip_w      = SCREEN_WIDTH_RST;
      clip_h      = SCREEN_HEIGHT_RST;
      drawing     = 1'b0;
      steep       = 1'b0;
      column      = '0;
      last_column = '0;
      intercept   = 0;
      slope       = 0;
      col_r       = '0;
      col_g       = '0;
      col_b       = '0;
      col_a       = '0;
      pixel_q.delete();
    end else begin
      if (out_valid && !out_stall) check_pixel(out_data);
      if (cfg_valid && cfg_ready) write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        if (in_data.mode == MODE_LINE) load_line(in_data);
        else trace_column();
      end
    end
    pending_count <= pixel_q.size();
  end

endmodule

// File: bench/antialiased_line_generator_tb.sv
// Stimulus and verdict for the antialiased line generator, checked by aaline_pixel_checker.
`timescale 1ns / 1ps

module antialiased_line_generator_tb;
  import aaline_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 40;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int fail_count;
  int pending;

  // Stimulus control, written by the main process; cycle_count is written by the watchdog
  bit                    tx_idle_en    = 1'b1;
  bit                    rx_idle_en    = 1'b1;
  int                    hold_requests = 0;
  int                    line_left     = 0;
  int                    useful_items  = 0;
  int                    cycle_count   = 0;
  bit                    cur_clip      = 1'b0;
  logic [CFG_DATA_W-1:0] cur_w         = SCREEN_WIDTH_RST;
  logic [CFG_DATA_W-1:0] cur_h         = SCREEN_HEIGHT_RST;

  antialiased_line_generator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  aaline_pixel_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (fail_count),
    .pending_count  (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver: random stall bursts, plus a long hold-off on request
  initial begin : receiver
    int stall_left;
    int holds_done;
    stall_left = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (stall_left == 0) begin
        if (holds_done < hold_requests) begin
          stall_left = LONG_HOLD;
          holds_done++;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 16);
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic int major_extent(input in_item_t it);
    int adx, ady;
    adx = (it.end_x >= it.start_x) ? int'(it.end_x) - int'(it.start_x)
                                   : int'(it.start_x) - int'(it.end_x);
    ady = (it.end_y >= it.start_y) ? int'(it.end_y) - int'(it.start_y)
                                   : int'(it.start_y) - int'(it.end_y);
    return (adx > ady) ? adx : ady;
  endfunction

  function automatic in_item_t line_item(input int sx, sy, ex, ey, input logic [31:0] rgba);
    in_item_t it;
    it.mode    = MODE_LINE;
    it.start_x = COORD_BITS'(sx);
    it.start_y = COORD_BITS'(sy);
    it.end_x   = COORD_BITS'(ex);
    it.end_y   = COORD_BITS'(ey);
    it.red     = rgba[31:24];
    it.green   = rgba[23:16];
    it.blue    = rgba[15:8];
    it.alpha   = rgba[7:0];
    return it;
  endfunction

  function automatic in_item_t random_payload();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(in_item_t)-1:0];
  endfunction

  // Offer one item, hold it until transfer, then maybe idle
  task automatic send_item(input in_item_t it);
    if (it.mode == MODE_LINE) begin
      line_left = major_extent(it);
      useful_items++;
    end else if (line_left > 0) begin
      line_left--;
      useful_items++;
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic send_steps(input int count);
    in_item_t it;
    repeat (count) begin
      it      = random_payload();
      it.mode = MODE_STEP;
      send_item(it);
    end
  endtask

  // Pause the sender until every predicted pixel is back, then let the block settle
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_screen(input bit clip, input logic [CFG_DATA_W-1:0] w, h);
    wait_drain();
    write_reg(CFG_CLIP_ENABLE, CFG_DATA_W'(clip));
    write_reg(CFG_SCREEN_WIDTH, w);
    write_reg(CFG_SCREEN_HEIGHT, h);
    cur_clip = clip;
    cur_w    = w;
    cur_h    = h;
  endtask

  // Random line; near keeps the start close to the clip window
  task automatic random_line(input int span, input bit near);
    int          sx, sy, ex, ey, xlim, ylim;
    logic [31:0] c;
    xlim = 511;
    ylim = 511;
    if (near) begin
      xlim = (int'(cur_w) + 3 > 511) ? 511 : int'(cur_w) + 3;
      ylim = (int'(cur_h) + 3 > 511) ? 511 : int'(cur_h) + 3;
    end
    sx = $urandom_range(0, xlim);
    sy = $urandom_range(0, ylim);
    ex = sx + int'($urandom_range(0, 2 * span)) - span;
    ey = sy + int'($urandom_range(0, 2 * span)) - span;
    if (ex < 0) ex = 0;
    if (ex > 511) ex = 511;
    if (ey < 0) ey = 0;
    if (ey > 511) ey = 511;
    c = $urandom;
    case ($urandom_range(0, 7))
      0: c[7:0] = 8'd0;
      1: c[7:0] = 8'd255;
      2: c[7:0] = 8'($urandom_range(1, 3));
      default: ;
    endcase
    send_item(line_item(sx, sy, ex, ey, c));
  endtask

  // Mostly whole lines, some cut short, some stray steps and point lines
  task automatic run_phase(input int budget);
    int first, pick, span, px, py;
    bit near;
    first = useful_items;
    while (useful_items - first < budget) begin
      pick = $urandom_range(0, 99);
      span = ($urandom_range(0, 79) == 0) ? 511 : int'($urandom_range(1, 12));
      near = cur_clip && ($urandom_range(0, 1) == 1);
      if (pick < 75) begin
        random_line(span, near);
        send_steps(line_left);
        if (pick < 8) send_steps($urandom_range(1, 2));
      end else if (pick < 87) begin
        random_line(span, near);
        send_steps($urandom_range(0, line_left));
      end else if (pick < 94) begin
        send_steps($urandom_range(1, 4));
      end else begin
        px = $urandom_range(0, 511);
        py = $urandom_range(0, 511);
        send_item(line_item(px, py, px, py, $urandom));
        send_steps($urandom_range(0, 1));
      end
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: point line then idle step, shallow, reversed, steep,
    // transparent, a line replaced mid-way, and slope of minus one
    send_item(line_item(5, 5, 5, 5, 32'h11223344));
    send_steps(1);
    send_item(line_item(0, 0, 3, 1, 32'hffffffff));
    send_steps(3);
    send_item(line_item(511, 511, 508, 509, 32'h000000ff));
    send_steps(3);
    send_item(line_item(10, 0, 12, 3, 32'h12345680));
    send_steps(3);
    send_item(line_item(0, 0, 2, 1, 32'hff00ff00));
    send_steps(2);
    send_item(line_item(0, 511, 3, 511, 32'ha55ac3ff));
    send_steps(1);
    send_item(line_item(100, 200, 97, 203, 32'h010204fe));
    send_steps(3);

    run_phase(280);

    // Full-size clip window; hold the receiver off while steps pile up
    set_screen(1'b1, 9'd511, 9'd511);
    tx_idle_en = 1'b0;
    hold_requests++;
    send_item(line_item(0, 5, 90, 40, 32'hc0ffeec8));
    send_steps(line_left);
    tx_idle_en = 1'b1;
    wait_drain();
    run_phase(280);

    // One-column and one-row windows
    set_screen(1'b1, 9'd1, 9'd511);
    run_phase(200);
    set_screen(1'b1, 9'd511, 9'd1);
    run_phase(200);

    // Random windows with clipping off, then on
    set_screen(1'b0, 9'($urandom_range(1, 511)), 9'($urandom_range(1, 511)));
    run_phase(280);
    set_screen(1'b1, 9'($urandom_range(1, 511)), 9'($urandom_range(1, 511)));
    run_phase(280);

    // Closing stretch at full rate on both sides
    set_screen(1'b1, SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_phase(250);

    wait_drain();
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
